// ----- rtl/core/weighted_random_pick_no_repeat_defines.svh -----
// assertion macros for the weighted random pick block
`ifndef WEIGHTED_RANDOM_PICK_NO_REPEAT_DEFINES_SVH
`define WEIGHTED_RANDOM_PICK_NO_REPEAT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WRPNR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define WRPNR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define WRPNR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define WRPNR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/wrpnr_pkg.sv -----
// shared types and constants of the weighted random pick block
`timescale 1ns / 1ps
`default_nettype none

package wrpnr_pkg;

   localparam int RANDOM_BITS = 15;
   localparam int COUNT_BITS  = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // register word index (paddr[2])
   localparam logic REG_ENTRY_COUNT = 1'b0;

   typedef struct packed {
      logic                   operation;
      logic [3:0]             entry_index;
      logic [7:0]             entry_weight;
      logic [RANDOM_BITS-1:0] random_value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [3:0] chosen_index;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/wrpnr_table.sv -----
// weight memory, one write port and one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module wrpnr_table #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/wrpnr_mod.sv -----
// bit-serial restoring modulo of the random value by the weight total
`timescale 1ns / 1ps
`default_nettype none

module wrpnr_mod #(
   parameter int DIVISOR_BITS = 13
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [wrpnr_pkg::RANDOM_BITS-1:0]  dividend,
   input  wire logic [DIVISOR_BITS-1:0]            divisor,
   output logic                                    done,
   output logic      [DIVISOR_BITS-1:0]            remainder
);

   localparam int STEPS  = wrpnr_pkg::RANDOM_BITS;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [STEPS-1:0]        quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0] div_ff, div_in;
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;

   logic [DIVISOR_BITS:0]   shifted;
   logic [DIVISOR_BITS:0]   diff;
   logic                    fits;

   // shift in the next dividend bit, subtract when it fits
   assign shifted = {rem_ff, quo_ff[STEPS-1]};
   assign fits    = (shifted >= {1'b0, div_ff});
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
         quo_in  = {quo_ff[STEPS-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/core/weighted_random_pick_no_repeat.sv -----
// top level of the weighted random pick with no immediate repeat
`timescale 1ns / 1ps
`default_nettype none

// Weighted random pick (roulette wheel) with no immediate repeat. A command is
// taken when start is high and busy is low. A load command writes one weight
// into the weight memory in its accept cycle and gives no result; busy stays
// low, so loads can follow every cycle. A draw command with n active entries
// (entry_count, clamped to MAX_ENTRIES) is handled as follows: with no active
// entries busy stays low and the result (found = 0) comes in the cycle after
// the accept; otherwise busy is raised until it is done, a first pass through
// the memory adds up the weights, a zero total ends the draw there with entry
// 0, a bit-serial modulo reduces the random value by the total, a second pass
// finds the first running sum above the reduced value, and a final state
// applies the repeat check. Both passes go through the single read port of the
// weight memory, one entry per cycle, and the modulo unit retires one dividend
// bit per cycle. Each result is shown on rsp_data for exactly one cycle with
// rsp_valid high; the receiver cannot hold it off and must take it in that
// cycle. The user must write the entry_count register through the csr port
// only while no draw is busy; the block itself does not enforce this.

`include "weighted_random_pick_no_repeat_defines.svh"

module weighted_random_pick_no_repeat #(
   parameter int MAX_ENTRIES = 16,
   parameter int WEIGHT_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // command channel
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire wrpnr_pkg::req_type                   req_data,
   // result channel
   output logic                                      rsp_valid,
   output wrpnr_pkg::rsp_type                        rsp_data,
   // register port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [wrpnr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [wrpnr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [wrpnr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                      csr_pready
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int NUM_W = $clog2(MAX_ENTRIES + 1);
   // n weights of WEIGHT_BITS each never overflow this
   localparam int SUM_W = WEIGHT_BITS + NUM_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MOD,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [wrpnr_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [NUM_W-1:0]                  n_ff, n_in;
   logic [NUM_W-1:0]                  issue_ff, issue_in;
   logic [NUM_W-1:0]                  recv_ff, recv_in;
   logic                              rd_vld_ff, rd_vld_in;
   logic [SUM_W-1:0]                  total_ff, total_in;
   logic [SUM_W-1:0]                  acc_ff, acc_in;
   logic [wrpnr_pkg::RANDOM_BITS-1:0] rnd_ff, rnd_in;
   logic [IDX_W-1:0]                  pick_ff, pick_in;
   logic [3:0]                        last_pick_ff, last_pick_in;
   logic                              last_valid_ff, last_valid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   wrpnr_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                   csr_write;
   logic [NUM_W-1:0]       n_clamp;
   logic                   tbl_we;
   logic [IDX_W-1:0]       tbl_waddr;
   logic [WEIGHT_BITS-1:0] tbl_wdata;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [WEIGHT_BITS-1:0] rd_data;
   logic [SUM_W-1:0]       acc_sum;
   logic                   mod_start;
   logic                   mod_done;
   logic [SUM_W-1:0]       mod_rem;
   logic [NUM_W-1:0]       pick_nx;
   logic                   is_repeat;
   logic [IDX_W-1:0]       pick_final;

   // register write completes in the access phase
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == wrpnr_pkg::REG_ENTRY_COUNT)
                     ? wrpnr_pkg::CSR_DATA_W'(count_ff) : '0;

   // counts above the table depth behave as a full table
   assign n_clamp = (32'(count_ff) > 32'(MAX_ENTRIES))
                  ? NUM_W'(MAX_ENTRIES) : NUM_W'(count_ff);

   // load path writes in the accept cycle
   assign tbl_waddr = IDX_W'(req_data.entry_index);
   assign tbl_wdata = WEIGHT_BITS'(req_data.entry_weight);

   // both passes read entry issue_ff, data back in the next cycle
   assign rd_addr = IDX_W'(issue_ff);
   assign acc_sum = acc_ff + SUM_W'(rd_data);

   // repeat avoidance: step to the next entry, wrapping at n
   assign pick_nx    = NUM_W'(pick_ff) + NUM_W'(1);
   assign is_repeat  = last_valid_ff && (32'(pick_ff) == 32'(last_pick_ff))
                     && (n_ff > NUM_W'(1));
   assign pick_final = !is_repeat ? pick_ff
                     : ((pick_nx == n_ff) ? '0 : IDX_W'(pick_nx));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      issue_in      = issue_ff;
      recv_in       = recv_ff;
      rd_vld_in     = 1'b0;
      total_in      = total_ff;
      acc_in        = acc_ff;
      rnd_in        = rnd_ff;
      pick_in       = pick_ff;
      last_pick_in  = last_pick_ff;
      last_valid_in = last_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      tbl_we        = 1'b0;
      rd_en         = 1'b0;
      mod_start     = 1'b0;

      if (csr_write && (csr_paddr[2] == wrpnr_pkg::REG_ENTRY_COUNT)) begin
         count_in = csr_pwdata[wrpnr_pkg::COUNT_BITS-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.operation == wrpnr_pkg::OP_LOAD) begin
                  // slots beyond the table are dropped
                  tbl_we = (32'(req_data.entry_index) < 32'(MAX_ENTRIES));
               end else begin
                  n_in   = n_clamp;
                  rnd_in = req_data.random_value;
                  if (n_clamp == '0) begin
                     // empty table: not found, record untouched
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.found        = 1'b0;
                     rsp_data_in.chosen_index = '0;
                  end else begin
                     issue_in = '0;
                     total_in = '0;
                     state_in = ST_SUM;
                  end
               end
            end
         end
         ST_SUM: begin
            rd_en     = (issue_ff < n_ff);
            rd_vld_in = rd_en;
            if (rd_en) begin
               issue_in = issue_ff + NUM_W'(1);
            end
            if (rd_vld_ff) begin
               total_in = total_ff + SUM_W'(rd_data);
            end
            if (!rd_en && !rd_vld_ff) begin
               if (total_ff == '0) begin
                  // all weights zero: entry 0, record untouched
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.found        = 1'b1;
                  rsp_data_in.chosen_index = '0;
                  state_in                 = ST_IDLE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               issue_in = '0;
               recv_in  = '0;
               acc_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd_en     = (issue_ff < n_ff);
            rd_vld_in = rd_en;
            if (rd_en) begin
               issue_in = issue_ff + NUM_W'(1);
            end
            if (rd_vld_ff) begin
               acc_in  = acc_sum;
               recv_in = recv_ff + NUM_W'(1);
               // reduced value is below the total, so this always hits
               if (mod_rem < acc_sum) begin
                  pick_in  = IDX_W'(recv_ff);
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.found        = 1'b1;
            rsp_data_in.chosen_index = 4'(pick_final);
            last_pick_in             = 4'(pick_final);
            last_valid_in            = 1'b1;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         last_pick_ff  <= '0;
         last_valid_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         last_pick_ff  <= last_pick_in;
         last_valid_ff <= last_valid_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff        <= n_in;
      issue_ff    <= issue_in;
      recv_ff     <= recv_in;
      total_ff    <= total_in;
      acc_ff      <= acc_in;
      rnd_ff      <= rnd_in;
      pick_ff     <= pick_in;
      rsp_data_ff <= rsp_data_in;
   end

   wrpnr_table #(
      .DEPTH  (MAX_ENTRIES),
      .DATA_W (WEIGHT_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wrpnr_mod #(
      .DIVISOR_BITS (SUM_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rnd_ff),
      .divisor   (total_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a load transfer never produces a result
   `WRPNR_ASSERT_NEXT(a_load_no_result, clock, reset,
      start && !busy && (req_data.operation == wrpnr_pkg::OP_LOAD), !rsp_valid)
   // not found always reports entry 0
   `WRPNR_ASSERT_IMPLY(a_not_found_zero, clock, reset,
      rsp_valid && !rsp_data.found, rsp_data.chosen_index == 4'd0)
   // every result strobe leaves the block ready for the next command
   `WRPNR_ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   // the final step of a draw always emits a found result
   `WRPNR_ASSERT_NEXT(a_done_emits, clock, reset,
      state_ff == ST_DONE, rsp_valid && rsp_data.found)
   // modulo completion only shows up while waiting for it
   `WRPNR_ASSERT_IMPLY(a_mod_done_in_mod, clock, reset, mod_done, state_ff == ST_MOD)

endmodule

`default_nettype wire

// ----- bench/weighted_random_pick_no_repeat_tb.sv -----
// self-checking regression bench for the weighted random pick block
`timescale 1ns / 1ps

module weighted_random_pick_no_repeat_tb;

   localparam int SLOT_COUNT   = 16;
   localparam int STALL_LIMIT  = 2000;   // cycles with no transfer before giving up
   localparam int SETTLE_TICKS = 4;      // a load has no result, let it retire
   localparam int TAIL_TICKS   = 64;     // quiet ticks before the final verdict
   localparam int REPORT_MAX   = 10;

   // register addresses: word index sits in paddr[2]
   localparam logic [wrpnr_pkg::CSR_ADDR_W-1:0] ADDR_ENTRY_COUNT =
      {wrpnr_pkg::REG_ENTRY_COUNT, 2'b00};
   localparam logic [wrpnr_pkg::CSR_ADDR_W-1:0] ADDR_UNMAPPED    =
      {~wrpnr_pkg::REG_ENTRY_COUNT, 2'b00};

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   wrpnr_pkg::req_type               req_data;
   logic                             rsp_valid;
   wrpnr_pkg::rsp_type               rsp_data;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [wrpnr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [wrpnr_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [wrpnr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;
   int                               stall_cycles;

   // roulette-wheel predictor plus the queue of picks still owed by the block
   class pick_scoreboard;
      logic [7:0]         weights [SLOT_COUNT];
      logic [3:0]         last_pick;
      bit                 last_valid;
      logic [4:0]         entry_count;
      wrpnr_pkg::rsp_type pending_picks [$];
      int                 mismatches;

      function new();
         foreach (weights[i]) weights[i] = '0;
         last_pick   = '0;
         last_valid  = 1'b0;
         entry_count = '0;
         mismatches  = 0;
      endfunction

      function void set_count(logic [4:0] value);
         entry_count = value;
      endfunction

      // one accepted command: loads update the table, draws owe one result
      function void note_transfer(wrpnr_pkg::req_type item);
         int unsigned        active;
         int unsigned        total;
         int unsigned        reduced;
         int unsigned        running;
         logic [3:0]         pick;
         wrpnr_pkg::rsp_type want;
         if (item.operation == wrpnr_pkg::OP_LOAD) begin
            weights[item.entry_index] = item.entry_weight;
            return;
         end
         active = (entry_count > SLOT_COUNT) ? SLOT_COUNT : entry_count;
         want = '0;
         // no active entries: not found, record untouched
         if (active == 0) begin
            pending_picks.push_back(want);
            return;
         end
         total = 0;
         for (int i = 0; i < active; i++) total += weights[i];
         want.found = 1'b1;
         // all active weights zero: entry 0, record untouched
         if (total == 0) begin
            pending_picks.push_back(want);
            return;
         end
         reduced = item.random_value % total;
         running = 0;
         pick    = '0;
         for (int i = 0; i < active; i++) begin
            running += weights[i];
            if (reduced < running) begin
               pick = 4'(i);
               break;
            end
         end
         // step past the previous pick, wrapping inside the active range
         if (last_valid && pick == last_pick && active > 1)
            pick = 4'((pick + 1) % active);
         last_pick         = pick;
         last_valid        = 1'b1;
         want.chosen_index = pick;
         pending_picks.push_back(want);
      endfunction

      function void check_result(wrpnr_pkg::rsp_type got);
         wrpnr_pkg::rsp_type want;
         if (pending_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected pick: found=%0b index=%0d", got.found, got.chosen_index);
            return;
         end
         want = pending_picks.pop_front();
         if (got.found !== want.found || got.chosen_index !== want.chosen_index) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("pick mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                        want.found, want.chosen_index, got.found, got.chosen_index);
         end
      endfunction
   endclass

   pick_scoreboard sb;

   weighted_random_pick_no_repeat dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: every transfer is taken at the rising edge that ends its cycle
   always @(posedge clock) begin
      if (!reset) begin
         // register write lands when the access phase completes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == wrpnr_pkg::REG_ENTRY_COUNT)
            sb.set_count(csr_pwdata[4:0]);
         if (start && !busy)
            sb.note_transfer(req_data);
         // the block cannot be held off, so every strobe is a result
         if (rsp_valid)
            sb.check_result(rsp_data);
      end
   end

   // watchdog: counts cycles in which no transfer of any kind happens
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("weighted_random_pick_no_repeat regression: fail");
         $finish;
      end
   end

   // setup then access phase, held until the port is ready
   task automatic csr_write(input logic [wrpnr_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [4:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      // upper data bits are noise the register must drop
      csr_pwdata  <= ($urandom() & ~32'h1f) | 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // optional idle gap, then hold the command until the block takes it
   task automatic send_command(input wrpnr_pkg::req_type item, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   // stop sending, wait for every owed pick, then let loads retire
   task automatic drain_picks();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   function automatic int idle_gap(input int pct);
      if ($urandom_range(99) < pct) return $urandom_range(1, 11);
      return 0;
   endfunction

   function automatic wrpnr_pkg::req_type load_cmd(input int slot, input int weight);
      wrpnr_pkg::req_type item;
      item              = wrpnr_pkg::req_type'($urandom());
      item.operation    = wrpnr_pkg::OP_LOAD;
      item.entry_index  = 4'(slot);
      item.entry_weight = 8'(weight);
      return item;
   endfunction

   function automatic wrpnr_pkg::req_type draw_cmd(input int value);
      wrpnr_pkg::req_type item;
      item              = wrpnr_pkg::req_type'($urandom());
      item.operation    = wrpnr_pkg::OP_DRAW;
      item.random_value = wrpnr_pkg::RANDOM_BITS'(value);
      return item;
   endfunction

   // random command: loads mostly aim at the active slots
   function automatic wrpnr_pkg::req_type random_cmd(input int active, input int zero_pct);
      int pick_kind;
      int slot;
      int weight;
      pick_kind = $urandom_range(9);
      if ($urandom_range(1)) begin
         if (pick_kind == 0)      return draw_cmd(0);
         else if (pick_kind == 1) return draw_cmd(32767);
         return draw_cmd($urandom_range(0, 32767));
      end
      if (active > 0 && $urandom_range(99) < 70)
         slot = $urandom_range(0, active - 1);
      else
         slot = $urandom_range(0, SLOT_COUNT - 1);
      if ($urandom_range(99) < zero_pct)  weight = 0;
      else if (pick_kind == 0)            weight = 255;
      else if (pick_kind < 4)             weight = $urandom_range(1, 7);
      else                                weight = $urandom_range(0, 255);
      return load_cmd(slot, weight);
   endfunction

   initial begin
      int count;
      int active;
      int idle_pct;
      int zero_pct;
      sb          = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // no active entries; a write to the unmapped word must not change that
      csr_write(ADDR_UNMAPPED, 5'd16);
      send_command(draw_cmd(0), 0);
      send_command(draw_cmd(32767), idle_gap(40));
      send_command(load_cmd(0, 0), 0);
      send_command(load_cmd(1, 0), idle_gap(40));
      drain_picks();

      // two entries: zero total first, then repeat avoidance both ways
      csr_write(ADDR_ENTRY_COUNT, 5'd2);
      send_command(draw_cmd(32767), 0);
      send_command(load_cmd(0, 255), 0);
      send_command(load_cmd(1, 1), idle_gap(40));
      send_command(draw_cmd(0), 0);       // first real pick, nothing to avoid
      send_command(draw_cmd(0), 0);       // same slot again, bumped to 1
      send_command(draw_cmd(255), 0);     // lands on 1, bumped and wrapped to 0
      send_command(draw_cmd(32767), idle_gap(40));
      drain_picks();

      // single entry never avoids a repeat
      csr_write(ADDR_ENTRY_COUNT, 5'd1);
      send_command(draw_cmd(100), 0);
      send_command(draw_cmd(7), 0);
      send_command(load_cmd(15, 255), 0);
      drain_picks();

      // random phases; count extremes first, the out-of-range one included
      for (int phase = 0; phase < 13; phase++) begin
         case (phase)
            0: count = 16;
            1: count = 31;
            2: count = 0;
            3: count = 1;
            4: count = 2;
            default: begin
               if ($urandom_range(3) == 0) count = $urandom_range(0, 31);
               else                        count = $urandom_range(1, 16);
            end
         endcase
         active = (count > SLOT_COUNT) ? SLOT_COUNT : count;
         if (phase % 2 == 1)
            csr_write(ADDR_UNMAPPED, 5'($urandom()));
         csr_write(ADDR_ENTRY_COUNT, 5'(count));
         // no idling at the end, plus quiet stretches along the way
         if (phase >= 11 || phase % 3 == 2) idle_pct = 0;
         else                               idle_pct = 30;
         // zero-heavy phases reach the zero-total case with many entries
         zero_pct = (phase % 4 == 3) ? 85 : 10;
         // every slot is written before any draw can read it
         if (phase == 0)
            for (int slot = 0; slot < SLOT_COUNT; slot++)
               send_command(load_cmd(slot, $urandom_range(0, 255)), idle_gap(idle_pct));
         for (int n = 0; n < 100; n++)
            send_command(random_cmd(active, zero_pct), idle_gap(idle_pct));
         drain_picks();
      end

      repeat (TAIL_TICKS) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_picks.size() == 0)
         $display("weighted_random_pick_no_repeat regression: pass");
      else
         $display("weighted_random_pick_no_repeat regression: fail");
      $finish;
   end

endmodule
